@@ rtl/footprint_collision_cost_macros.svh @@
// ----------------------------------------------------------------------------
// Footprint collision cost assertion macros
// Shared concurrent assertion forms for the collision check block.
// ----------------------------------------------------------------------------
`ifndef FOOTPRINT_COLLISION_COST_MACROS_SVH
`define FOOTPRINT_COLLISION_COST_MACROS_SVH

// same-cycle implication
`define FCC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcc assertion failed");

// next-cycle implication
`define FCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcc assertion failed");

`endif

@@ rtl/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Footprint collision cost package
// Types, constants and the cell cost function shared by the block.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;

   // coordinate width covering the largest map dimension
   localparam int CRD_W = 13;

   localparam logic [7:0] LETHAL = 8'd254;
   // floor(v*254/100) == (v * 254 * ceil(2^20/100)) >> 20 for v in 0..127
   localparam logic [28:0] COST_RECIP = 29'd2663444;
   localparam int          COST_SHIFT = 20;

   typedef enum logic [2:0] {
      CSR_THRESHOLD, CSR_TRACK_UNKNOWN, CSR_ORIGIN_X, CSR_ORIGIN_Y,
      CSR_CELLS_PER_METER, CSR_RADIUS_SQ, CSR_MAP_WIDTH, CSR_MAP_HEIGHT
   } fcc_csr_type;

   typedef enum logic [1:0] {
      KIND_WRITE, KIND_NOMAP, KIND_OFFMAP, KIND_SCAN
   } fcc_kind_type;

   typedef struct packed {
      fcc_kind_type       kind;
      logic [CRD_W-1:0]   col;
      logic [CRD_W-1:0]   row;
      logic signed [7:0]  value;
   } fcc_entry_type;

   typedef struct packed {
      logic [6:0]         obstacle_level;
      logic               track_unknown;
      logic signed [23:0] origin_x;
      logic signed [23:0] origin_y;
      logic [15:0]        cells_per_meter;
      logic [10:0]        footprint_radius_sq;
      logic [8:0]         map_width;
      logic [8:0]         map_height;
   } fcc_cfg_type;

   function automatic logic [7:0] cell_cost(logic signed [7:0] v, logic trk);
      logic [28:0] q;
      logic [8:0]  c;
      q = 29'(v[6:0]) * COST_RECIP;
      c = 9'(q >> COST_SHIFT);
      if (v[7]) begin
         return trk ? 8'd0 : LETHAL;
      end
      return (c > 9'(LETHAL)) ? LETHAL : c[7:0];
   endfunction

endpackage

@@ rtl/fcc_queue.sv @@
// ----------------------------------------------------------------------------
// Footprint collision cost queue
// Small FIFO between the front classifier and the scan engine.
// ----------------------------------------------------------------------------
module fcc_queue import fcc_pkg::*; #(
   parameter int WIDTH = $bits(fcc_entry_type),
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ rtl/fcc_front.sv @@
// ----------------------------------------------------------------------------
// Footprint collision cost front end
// Accepts beats, converts query poses to cells and classifies them.
// ----------------------------------------------------------------------------
module fcc_front import fcc_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  fcc_cfg_type        cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [7:0]         req_cell_col,
   input  logic [7:0]         req_cell_row,
   input  logic signed [7:0]  req_cell_value,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   output logic               push,
   output fcc_entry_type      push_data,
   input  logic               full
);
   typedef enum logic [1:0] {F_IDLE, F_SUB, F_MUL, F_CLS} fstate_type;

   fstate_type         state_ff;
   logic               mode_ff;
   logic [7:0]         col_ff, row_ff;
   logic signed [7:0]  val_ff;
   logic signed [23:0] posx_ff, posy_ff;
   logic [24:0]        magx_ff, magy_ff;
   logic               negx_ff, negy_ff;
   logic [40:0]        prodx_ff, prody_ff;

   logic [24:0]      diffx, diffy, cellx, celly, w_ext, h_ext;
   logic [CRD_W-1:0] w_c, h_c;
   logic             offx, offy;

   assign diffx = {posx_ff[23], posx_ff} - {cfg.origin_x[23], cfg.origin_x};
   assign diffy = {posy_ff[23], posy_ff} - {cfg.origin_y[23], cfg.origin_y};

   // map size clamped to the grid
   assign w_c = (32'(cfg.map_width) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH)
                                                 : CRD_W'(cfg.map_width);
   assign h_c = (32'(cfg.map_height) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT)
                                                   : CRD_W'(cfg.map_height);
   assign w_ext = 25'(w_c);
   assign h_ext = 25'(h_c);

   // truncation toward zero: magnitude shifted, sign kept aside
   assign cellx = prodx_ff[40:16];
   assign celly = prody_ff[40:16];
   assign offx  = (negx_ff && cellx != '0) || (cellx >= w_ext);
   assign offy  = (negy_ff && celly != '0) || (celly >= h_ext);

   assign req_ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_CLS) && !full;

   always_comb begin
      push_data.col   = CRD_W'(col_ff);
      push_data.row   = CRD_W'(row_ff);
      push_data.value = val_ff;
      push_data.kind  = KIND_WRITE;
      if (mode_ff) begin
         push_data.col   = CRD_W'(cellx);
         push_data.row   = CRD_W'(celly);
         if (cfg.map_width == '0) begin
            push_data.kind = KIND_NOMAP;
         end else if (offx || offy) begin
            push_data.kind = KIND_OFFMAP;
         end else begin
            push_data.kind = KIND_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  state_ff <= req_mode ? F_SUB : F_CLS;
               end
            end
            F_SUB: state_ff <= F_MUL;
            F_MUL: state_ff <= F_CLS;
            F_CLS: begin
               if (!full) begin
                  state_ff <= F_IDLE;
               end
            end
         endcase
      end
      if (state_ff == F_IDLE && req_valid) begin
         mode_ff <= req_mode;
         col_ff  <= req_cell_col;
         row_ff  <= req_cell_row;
         val_ff  <= req_cell_value;
         posx_ff <= req_pos_x;
         posy_ff <= req_pos_y;
      end
      if (state_ff == F_SUB) begin
         negx_ff <= diffx[24];
         negy_ff <= diffy[24];
         magx_ff <= diffx[24] ? -diffx : diffx;
         magy_ff <= diffy[24] ? -diffy : diffy;
      end
      if (state_ff == F_MUL) begin
         prodx_ff <= 41'(magx_ff) * 41'(cfg.cells_per_meter);
         prody_ff <= 41'(magy_ff) * 41'(cfg.cells_per_meter);
      end
   end
endmodule

@@ rtl/fcc_back.sv @@
// ----------------------------------------------------------------------------
// Footprint collision cost back end
// Holds the grid, stores cell writes and scans the footprint of a query.
// ----------------------------------------------------------------------------
module fcc_back import fcc_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  fcc_cfg_type   cfg,
   input  fcc_entry_type entry,
   input  logic          empty,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_collision,
   output logic [7:0]    rsp_footprint_cost,
   output logic [7:0]    rsp_center_cost
);
   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int RW    = $clog2(MAX_RADIUS + 1) + 1;
   localparam int GW    = CRD_W + RW + 1;
   localparam int SW    = 2 * RW + 1;
   localparam logic signed [RW-1:0] R_LO = RW'(-MAX_RADIUS);
   localparam logic signed [RW-1:0] R_HI = RW'(MAX_RADIUS);

   typedef enum logic [1:0] {B_IDLE, B_SCAN, B_DRAIN, B_DONE} bstate_type;

   logic [7:0] grid_mem [DEPTH];

   bstate_type          state_ff;
   logic [CRD_W-1:0]    cx_ff, cy_ff;
   logic signed [RW-1:0] dx_ff, dy_ff;
   logic                p_valid_ff, p_foot_ff, p_off_ff, p_center_ff;
   logic signed [7:0]   rd_ff;
   logic                off_ff, coll_ff;
   logic [7:0]          fcost_ff, ccost_ff;
   logic                rsp_valid_ff, rsp_coll_ff;
   logic [7:0]          rsp_fcost_ff, rsp_ccost_ff;

   logic signed [GW-1:0] gx, gy;
   logic [GW-1:0]        w_ext, h_ext;
   logic [CRD_W-1:0]     w_c, h_c;
   logic [RW-1:0]        adx, ady;
   logic [SW-1:0]        dsum;
   logic [SW+3:0]        d2;
   logic                 in_foot, on_map, last, out_free, wr_en, rsp_load;
   logic [AW-1:0]        raddr, waddr;
   logic [7:0]           rd_cost;

   assign w_c = (32'(cfg.map_width) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH)
                                                 : CRD_W'(cfg.map_width);
   assign h_c = (32'(cfg.map_height) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT)
                                                   : CRD_W'(cfg.map_height);
   assign w_ext = GW'(w_c);
   assign h_ext = GW'(h_c);

   assign gx = $signed(GW'(cx_ff)) + GW'(dx_ff);
   assign gy = $signed(GW'(cy_ff)) + GW'(dy_ff);
   assign on_map = !gx[GW-1] && !gy[GW-1] && ($unsigned(gx) < w_ext)
                   && ($unsigned(gy) < h_ext);

   assign adx  = dx_ff[RW-1] ? -dx_ff : dx_ff;
   assign ady  = dy_ff[RW-1] ? -dy_ff : dy_ff;
   assign dsum = SW'(adx) * SW'(adx) + SW'(ady) * SW'(ady);
   assign d2   = {dsum, 4'b0000};
   assign in_foot = (d2 <= (SW+4)'(cfg.footprint_radius_sq));
   assign last    = (dx_ff == R_HI) && (dy_ff == R_HI);

   assign raddr = AW'(gy) * AW'(MAX_WIDTH) + AW'(gx);
   assign waddr = AW'(entry.row) * AW'(MAX_WIDTH) + AW'(entry.col);
   assign rd_cost = cell_cost(rd_ff, cfg.track_unknown);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop = (state_ff == B_IDLE) && !empty
                && (entry.kind == KIND_WRITE || entry.kind == KIND_SCAN || out_free);
   assign wr_en = pop && entry.kind == KIND_WRITE
                  && 32'(entry.col) < MAX_WIDTH && 32'(entry.row) < MAX_HEIGHT;
   assign rsp_load = (pop && (entry.kind == KIND_NOMAP || entry.kind == KIND_OFFMAP))
                     || (state_ff == B_DONE && out_free);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_collision      = rsp_coll_ff;
   assign rsp_footprint_cost = rsp_fcost_ff;
   assign rsp_center_cost    = rsp_ccost_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[waddr] <= entry.value;
      end
      rd_ff <= grid_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         p_valid_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         p_valid_ff <= (state_ff == B_SCAN);
         unique case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  unique case (entry.kind)
                     KIND_WRITE: ;
                     KIND_NOMAP: begin
                        rsp_coll_ff  <= 1'b1;
                        rsp_fcost_ff <= LETHAL;
                        rsp_ccost_ff <= 8'd0;
                     end
                     KIND_OFFMAP: begin
                        rsp_coll_ff  <= 1'b1;
                        rsp_fcost_ff <= LETHAL;
                        rsp_ccost_ff <= LETHAL;
                     end
                     KIND_SCAN: begin
                        state_ff <= B_SCAN;
                        cx_ff    <= entry.col;
                        cy_ff    <= entry.row;
                        dx_ff    <= R_LO;
                        dy_ff    <= R_LO;
                        off_ff   <= 1'b0;
                        coll_ff  <= 1'b0;
                        fcost_ff <= 8'd0;
                     end
                  endcase
               end
            end
            B_SCAN: begin
               if (dy_ff == R_HI) begin
                  dy_ff <= R_LO;
                  dx_ff <= dx_ff + 1'b1;
               end else begin
                  dy_ff <= dy_ff + 1'b1;
               end
               if (last) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: state_ff <= B_DONE;
            B_DONE: begin
               if (out_free) begin
                  rsp_coll_ff  <= coll_ff || off_ff;
                  rsp_fcost_ff <= off_ff ? LETHAL : fcost_ff;
                  rsp_ccost_ff <= ccost_ff;
                  state_ff     <= B_IDLE;
               end
            end
         endcase
      end
      // offset flags travel alongside the registered memory read
      p_foot_ff   <= in_foot;
      p_off_ff    <= !on_map;
      p_center_ff <= (dx_ff == '0) && (dy_ff == '0);
      if (p_valid_ff && p_foot_ff) begin
         if (p_off_ff) begin
            off_ff <= 1'b1;
         end else begin
            if (!rd_ff[7] && rd_ff[6:0] >= cfg.obstacle_level) begin
               coll_ff <= 1'b1;
            end
            if (rd_cost > fcost_ff) begin
               fcost_ff <= rd_cost;
            end
         end
      end
      if (p_valid_ff && p_center_ff) begin
         ccost_ff <= rd_cost;
      end
   end
endmodule

@@ rtl/footprint_collision_cost.sv @@
// ----------------------------------------------------------------------------
// Footprint collision cost
// Occupancy grid with circular footprint collision check and cost lookup.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | beat
//   req     | in  | req_valid/ready    | cell write or pose query
//   rsp     | out | rsp_valid/ready    | collision, footprint and center cost
//   csr     | in  | csr_write_enable   | register write, no wait
//
// A cell write is registered in the front, queued and stored in the grid
// when the back end pops it; it gives no result. A query passes the front
// states F_SUB, F_MUL and F_CLS and the queue; the back end then scans the
// offsets within MAX_RADIUS, one footprint cell per cycle through the single
// grid read port, before rsp_valid rises. Queries with no map or an off-map
// center skip the scan. Reset does not clear the grid; registers return to
// their defaults. A two-entry queue lets the front take beats while a scan
// runs; a stalled rsp holds the back end, and the front once the queue fills.
module footprint_collision_cost import fcc_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [7:0]         req_cell_col,
   input  logic [7:0]         req_cell_row,
   input  logic signed [7:0]  req_cell_value,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_collision,
   output logic [7:0]         rsp_footprint_cost,
   output logic [7:0]         rsp_center_cost,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_write_data
);
`include "footprint_collision_cost_macros.svh"

   fcc_cfg_type   cfg_ff;
   fcc_entry_type push_data, pop_data;
   logic          push, pop, full, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_level      <= 7'd65;
         cfg_ff.track_unknown       <= 1'b0;
         cfg_ff.origin_x            <= '0;
         cfg_ff.origin_y            <= '0;
         cfg_ff.cells_per_meter     <= 16'd5120;
         cfg_ff.footprint_radius_sq <= 11'd64;
         cfg_ff.map_width           <= '0;
         cfg_ff.map_height          <= '0;
      end else if (csr_write_enable) begin
         unique case (fcc_csr_type'(csr_index))
            CSR_THRESHOLD:       cfg_ff.obstacle_level      <= csr_write_data[6:0];
            CSR_TRACK_UNKNOWN:   cfg_ff.track_unknown       <= csr_write_data[0];
            CSR_ORIGIN_X:        cfg_ff.origin_x            <= csr_write_data;
            CSR_ORIGIN_Y:        cfg_ff.origin_y            <= csr_write_data;
            CSR_CELLS_PER_METER: cfg_ff.cells_per_meter     <= csr_write_data[15:0];
            CSR_RADIUS_SQ:       cfg_ff.footprint_radius_sq <= csr_write_data[10:0];
            CSR_MAP_WIDTH:       cfg_ff.map_width           <= csr_write_data[8:0];
            CSR_MAP_HEIGHT:      cfg_ff.map_height          <= csr_write_data[8:0];
         endcase
      end
   end

   fcc_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_cell_col  (req_cell_col),
      .req_cell_row  (req_cell_row),
      .req_cell_value(req_cell_value),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .push          (push),
      .push_data     (push_data),
      .full          (full)
   );

   fcc_queue #(
      .WIDTH($bits(fcc_entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (empty)
   );

   fcc_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RADIUS(MAX_RADIUS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .entry             (pop_data),
      .empty             (empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_collision     (rsp_collision),
      .rsp_footprint_cost(rsp_footprint_cost),
      .rsp_center_cost   (rsp_center_cost)
   );

   `FCC_ASSERT_IMP(a_no_push_full, clock, reset, push, !full)
   `FCC_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !empty)
   `FCC_ASSERT_NEXT(a_scan_blocks_pop, clock, reset, pop && pop_data.kind == KIND_SCAN, !pop)
   `FCC_ASSERT_IMP(a_cost_range, clock, reset, rsp_valid,
                   rsp_footprint_cost <= LETHAL && rsp_center_cost <= LETHAL)
endmodule
